### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// Each macro writes one labeled concurrent assertion clocked on the rising
// edge and disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define SRME_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("srme assertion failed (same-cycle implication)");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define SRME_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("srme assertion failed (next-cycle implication)");

`endif

### rtl/srme_pkg.sv
// ---------------------------------------------------------------------------
// srme_pkg
// Widths, constants and state type of the symbol rate exponent/mantissa
// encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package srme_pkg;

  // Field widths.
  localparam int RATE_W = 24;
  localparam int XOSC_W = 27;
  localparam int MANT_W = 20;
  localparam int EXP_W  = 4;
  localparam int ACT_W  = 32;

  // Encoding constants.
  localparam int MAX_EXP      = 15;
  localparam int SHIFT_BASE   = 38;
  localparam int SHIFT_RAISED = 39;

  // Long division of rate * 2^SHIFT_BASE, one quotient bit per step.
  localparam int DIV_STEPS = RATE_W + SHIFT_BASE;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  // Step count at which the quotient first belongs to exponent MAX_EXP.
  localparam int CHK_FIRST = RATE_W + SHIFT_RAISED - MAX_EXP;
  // Exponent for a given step count is E_BASE minus the count.
  localparam int E_BASE    = RATE_W + SHIFT_RAISED;

  // Raw mantissa including the implicit leading one, and the kept quotient.
  localparam int RAW_W = MANT_W + 1;
  localparam int Q_W   = MANT_W + 2;

  // Back-conversion multiply and rounding.
  localparam int PROD_W = RAW_W + XOSC_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH_W   = $clog2(SHIFT_RAISED + 1);
  localparam int MCNT_W = $clog2(RAW_W);
  // Realized rate never needs more bits than this.
  localparam int ACT_MAX_W = PROD_W - (SHIFT_RAISED - MAX_EXP) + 1;

  localparam logic [XOSC_W-1:0] XOSC_RESET = XOSC_W'(40000000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PICK,
    ST_MUL,
    ST_RND,
    ST_SHR
  } srme_state_t;

endpackage

`default_nettype wire

### rtl/srme_in_if.sv
// ---------------------------------------------------------------------------
// srme_in_if
// Request channel: valid/ready handshake carrying the requested symbol rate.
// ---------------------------------------------------------------------------
`default_nettype none

interface srme_in_if;
  import srme_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] requested_rate;

  modport source (output valid, output requested_rate, input ready);
  modport sink   (input valid, input requested_rate, output ready);
endinterface

`default_nettype wire

### rtl/srme_out_if.sv
// ---------------------------------------------------------------------------
// srme_out_if
// Result channel: valid/ready handshake carrying the encoded rate fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface srme_out_if;
  import srme_pkg::*;

  logic              valid;
  logic              ready;
  logic [EXP_W-1:0]  rate_exponent;
  logic [MANT_W-1:0] rate_mantissa;
  logic [ACT_W-1:0]  actual_rate;
  logic              mantissa_saturated;

  modport source (output valid, output rate_exponent, output rate_mantissa,
                  output actual_rate, output mantissa_saturated, input ready);
  modport sink   (input valid, input rate_exponent, input rate_mantissa,
                  input actual_rate, input mantissa_saturated, output ready);
endinterface

`default_nettype wire

### rtl/symbol_rate_exp_mantissa_encoder_top.sv
// A request is worked on from its transfer until its result is loaded into the
// output register; the block takes no new request meanwhile. Work is a bit-serial
// long division by the crystal frequency, then a shift-add multiply.
// A result waiting in the output register does not block a new request.
// Reset (rst_n low, synchronous): idle, output empty, crystal 40 MHz.
// ---------------------------------------------------------------------------
// symbol_rate_exp_mantissa_encoder_top
// Encodes a requested symbol rate as exponent and mantissa relative to the
// configured crystal frequency and returns the rate the encoding realizes.
// ---------------------------------------------------------------------------
`default_nettype none

module symbol_rate_exp_mantissa_encoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [srme_pkg::XOSC_W-1:0] cfg_wdata,
  srme_in_if.sink                     in_ch,
  srme_out_if.source                  out_ch
);
  import srme_pkg::*;

  srme_state_t state_r, state_nxt;

  logic [XOSC_W-1:0] xosc_cfg_r;

  // Division datapath.
  logic [RATE_W-1:0] rate_sh_r, rate_sh_nxt;
  logic [XOSC_W-1:0] xd_r, xd_nxt;
  logic [XOSC_W-1:0] xh_r, xh_nxt;
  logic [XOSC_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic              qbig_r, qbig_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Best exponent seen so far.
  logic              rec_vld_r, rec_vld_nxt;
  logic [EXP_W-1:0]  rec_exp_r, rec_exp_nxt;
  logic [RAW_W-1:0]  rec_raw_r, rec_raw_nxt;
  logic              e0_r, e0_nxt;

  // Chosen encoding and back-conversion.
  logic [EXP_W-1:0]  res_exp_r, res_exp_nxt;
  logic [MANT_W-1:0] res_mant_r, res_mant_nxt;
  logic              res_sat_r, res_sat_nxt;
  logic [RAW_W-1:0]  m_sh_r, m_sh_nxt;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [EXP_W-1:0]  out_exp_r, out_exp_nxt;
  logic [MANT_W-1:0] out_mant_r, out_mant_nxt;
  logic [ACT_W-1:0]  out_act_r, out_act_nxt;
  logic              out_sat_r, out_sat_nxt;

  // Helper signals.
  logic [XOSC_W-1:0] xsel;
  logic [XOSC_W:0]   trial;
  logic              ge;
  logic              inc;
  logic [Q_W-1:0]    qsum;
  logic              fits21;
  logic              fits20;
  logic              chk_en;
  logic [CNT_W:0]    e_calc;
  logic              out_ld;
  logic [ACC_W-1:0]  act_shift;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ld      = (state_r == ST_SHR) && (!out_valid_r || out_ch.ready);

  // A crystal frequency of zero is treated as one hertz.
  assign xsel = (xosc_cfg_r == '0) ? XOSC_W'(1) : xosc_cfg_r;

  // One restoring division step on the remainder.
  assign trial = {rem_r, rate_sh_r[RATE_W-1]};
  assign ge    = (trial >= {1'b0, xd_r});

  // Round half up: the quotient gains one when the remainder reaches ceil(X/2).
  assign inc    = (rem_r >= xh_r);
  assign qsum   = {1'b0, q_r[RAW_W-1:0]} + Q_W'(inc);
  assign fits21 = !qbig_r && !q_r[Q_W-1] && !qsum[RAW_W];
  assign fits20 = fits21 && !qsum[MANT_W];
  assign chk_en = (cnt_r >= CNT_W'(CHK_FIRST));
  assign e_calc = (CNT_W+1)'(E_BASE) - {1'b0, cnt_r};

  assign act_shift = acc_r >> sh_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNT_W'(DIV_STEPS)) state_nxt = ST_PICK;
      ST_PICK: state_nxt = ST_MUL;
      ST_MUL:  if (mcnt_r == MCNT_W'(RAW_W - 1)) state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_SHR;
      ST_SHR:  if (out_ld) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    rate_sh_nxt  = rate_sh_r;
    xd_nxt       = xd_r;
    xh_nxt       = xh_r;
    rem_nxt      = rem_r;
    q_nxt        = q_r;
    qbig_nxt     = qbig_r;
    cnt_nxt      = cnt_r;
    rec_vld_nxt  = rec_vld_r;
    rec_exp_nxt  = rec_exp_r;
    rec_raw_nxt  = rec_raw_r;
    e0_nxt       = e0_r;
    res_exp_nxt  = res_exp_r;
    res_mant_nxt = res_mant_r;
    res_sat_nxt  = res_sat_r;
    m_sh_nxt     = m_sh_r;
    sh_nxt       = sh_r;
    mcnt_nxt     = mcnt_r;
    acc_nxt      = acc_r;
    out_exp_nxt  = out_exp_r;
    out_mant_nxt = out_mant_r;
    out_act_nxt  = out_act_r;
    out_sat_nxt  = out_sat_r;

    unique case (state_r)
      ST_IDLE: begin
        // Load the request on its transfer.
        if (in_ch.valid) begin
          rate_sh_nxt = in_ch.requested_rate;
          xd_nxt      = xsel;
          xh_nxt      = XOSC_W'(({1'b0, xsel} + (XOSC_W+1)'(1)) >> 1);
          rem_nxt     = '0;
          q_nxt       = '0;
          qbig_nxt    = 1'b0;
          cnt_nxt     = '0;
          rec_vld_nxt = 1'b0;
          e0_nxt      = 1'b0;
        end
      end
      ST_DIV: begin
        // Record the largest shift whose rounded quotient fits the mantissa.
        if (chk_en && fits21) begin
          rec_vld_nxt = 1'b1;
          rec_exp_nxt = e_calc[EXP_W-1:0];
          rec_raw_nxt = qsum[RAW_W-1:0];
        end
        if (cnt_r == CNT_W'(DIV_STEPS)) begin
          e0_nxt = fits20;
        end else begin
          rem_nxt     = ge ? XOSC_W'(trial - {1'b0, xd_r}) : trial[XOSC_W-1:0];
          q_nxt       = {q_r[Q_W-2:0], ge};
          qbig_nxt    = qbig_r | q_r[Q_W-1];
          rate_sh_nxt = {rate_sh_r[RATE_W-2:0], 1'b0};
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
      end
      ST_PICK: begin
        // Choose exponent, mantissa and the back-conversion operands.
        if (e0_r) begin
          res_exp_nxt  = '0;
          res_mant_nxt = rec_raw_r[MANT_W-1:0];
          res_sat_nxt  = 1'b0;
          m_sh_nxt     = {1'b0, rec_raw_r[MANT_W-1:0]};
          sh_nxt       = SH_W'(SHIFT_BASE);
        end else if (rec_vld_r) begin
          res_exp_nxt  = rec_exp_r;
          res_mant_nxt = rec_raw_r[MANT_W] ? rec_raw_r[MANT_W-1:0] : '0;
          res_sat_nxt  = 1'b0;
          m_sh_nxt     = {1'b1, (rec_raw_r[MANT_W] ? rec_raw_r[MANT_W-1:0] : MANT_W'(0))};
          sh_nxt       = SH_W'(SHIFT_RAISED) - SH_W'(rec_exp_r);
        end else begin
          res_exp_nxt  = EXP_W'(MAX_EXP);
          res_mant_nxt = '1;
          res_sat_nxt  = 1'b1;
          m_sh_nxt     = '1;
          sh_nxt       = SH_W'(SHIFT_RAISED - MAX_EXP);
        end
        mcnt_nxt = '0;
        acc_nxt  = '0;
      end
      ST_MUL: begin
        // Shift-add multiply, mantissa bits taken MSB first.
        acc_nxt  = {acc_r[ACC_W-2:0], 1'b0} + (m_sh_r[RAW_W-1] ? ACC_W'(xd_r) : ACC_W'(0));
        m_sh_nxt = {m_sh_r[RAW_W-2:0], 1'b0};
        mcnt_nxt = mcnt_r + MCNT_W'(1);
      end
      ST_RND: begin
        // Add half of the final divisor for round half up.
        acc_nxt = acc_r + (ACC_W'(1) << (sh_r - SH_W'(1)));
      end
      ST_SHR: begin
        if (out_ld) begin
          out_exp_nxt  = res_exp_r;
          out_mant_nxt = res_mant_r;
          out_sat_nxt  = res_sat_r;
          out_act_nxt  = act_shift[ACT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output valid: set on load, cleared on transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      xosc_cfg_r  <= XOSC_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        xosc_cfg_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rate_sh_r  <= rate_sh_nxt;
    xd_r       <= xd_nxt;
    xh_r       <= xh_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    qbig_r     <= qbig_nxt;
    cnt_r      <= cnt_nxt;
    rec_vld_r  <= rec_vld_nxt;
    rec_exp_r  <= rec_exp_nxt;
    rec_raw_r  <= rec_raw_nxt;
    e0_r       <= e0_nxt;
    res_exp_r  <= res_exp_nxt;
    res_mant_r <= res_mant_nxt;
    res_sat_r  <= res_sat_nxt;
    m_sh_r     <= m_sh_nxt;
    sh_r       <= sh_nxt;
    mcnt_r     <= mcnt_nxt;
    acc_r      <= acc_nxt;
    out_exp_r  <= out_exp_nxt;
    out_mant_r <= out_mant_nxt;
    out_act_r  <= out_act_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.rate_exponent      = out_exp_r;
  assign out_ch.rate_mantissa      = out_mant_r;
  assign out_ch.actual_rate        = out_act_r;
  assign out_ch.mantissa_saturated = out_sat_r;

endmodule

`default_nettype wire

### rtl/srme_checker.sv
// ---------------------------------------------------------------------------
// srme_checker
// Port-level assertions for the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srme_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic [srme_pkg::EXP_W-1:0] out_exp,
  input logic [srme_pkg::ACT_W-1:0] out_actual,
  input logic                       out_sat
);
  import srme_pkg::*;

  // A request transfer starts work, so the block is busy on the next cycle.
  `SRME_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready)

  // Saturation only happens at the highest exponent.
  `SRME_ASSERT_IMP(a_sat_max_exp, clk, rst_n, out_valid && out_sat, out_exp == EXP_W'(MAX_EXP))

  // A new result appears only out of a busy cycle.
  `SRME_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

  // The realized rate stays within the range the encoding can reach.
  `SRME_ASSERT_IMP(a_actual_range, clk, rst_n, out_valid, out_actual[ACT_W-1:ACT_MAX_W] == '0)

endmodule

bind symbol_rate_exp_mantissa_encoder_top srme_checker u_srme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_exp    (out_ch.rate_exponent),
  .out_actual (out_ch.actual_rate),
  .out_sat    (out_ch.mantissa_saturated)
);

`default_nettype wire
